// ===== hw/rtl/abs_pkg.sv =====
// Shared types and codes for the alternating-bit sender.
package abs_pkg;

  localparam int PAYLOAD_W = 160;
  localparam int SUM_W     = 13;
  localparam int NBYTES    = PAYLOAD_W / 8;

  typedef logic [PAYLOAD_W-1:0] payload_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [1:0] {
    CMD_MSG     = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

endpackage

// ===== hw/rtl/abs_checksum.sv =====
// Packet checksum: sequence bit plus the twenty payload bytes taken as signed.
module abs_checksum (
  input  logic             seq,
  input  abs_pkg::payload_t payload,
  output abs_pkg::sum_t    sum
);
  import abs_pkg::*;

  sum_t byte_val [NBYTES];
  sum_t pair_sum [NBYTES/2];
  sum_t quad_sum [NBYTES/4];

  // The bytes are summed as a balanced tree so the carry path stays short.
  always_comb begin
    for (int i = 0; i < NBYTES; i++) begin
      byte_val[i] = {{(SUM_W-8){payload[8*i+7]}}, payload[8*i +: 8]};
    end
    for (int i = 0; i < NBYTES/2; i++) begin
      pair_sum[i] = byte_val[2*i] + byte_val[2*i+1];
    end
    for (int i = 0; i < NBYTES/4; i++) begin
      quad_sum[i] = pair_sum[2*i] + pair_sum[2*i+1];
    end
    sum = ((quad_sum[0] + quad_sum[1]) + (quad_sum[2] + quad_sum[3]))
        + (quad_sum[4] + {{(SUM_W-1){1'b0}}, seq});
  end

endmodule

// ===== hw/rtl/alternating_bit_sender_core.sv =====
// Sender side of the alternating-bit protocol: a queued message source with resend on timeout.
//
// Each transaction first reads the head entry of the message queue memory when it is accepted,
// then, in the execute state, updates the queue, the sequence bit and the
// result registers, so done pulses for one cycle right after and busy is low again in that
// same cycle. Every transaction yields exactly one result, and the receiver cannot stall it.
// The queue memory holds QUEUE_DEPTH messages of twenty bytes; it needs no clearing after reset.
module alternating_bit_sender_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       command,
  input  logic [63:0]      msg_word0,
  input  logic [63:0]      msg_word1,
  input  logic [31:0]      msg_word2,
  input  logic             ack_bit,
  output logic             done,
  output logic             send_valid,
  output logic             send_seq,
  output logic [63:0]      send_word0,
  output logic [63:0]      send_word1,
  output logic [31:0]      send_word2,
  output abs_pkg::sum_t    send_sum,
  output logic             timer_start,
  output logic             timer_stop,
  output logic             dropped
);
  import abs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t           state;
  logic [1:0]       cmd_reg;
  payload_t         msg_reg;
  logic             ack_reg;
  logic             seq_bit;
  logic             waiting;
  payload_t         last_payload;
  logic [PTR_W-1:0] queue_head;
  logic [PTR_W-1:0] queue_tail;
  logic [CNT_W-1:0] queue_count;

  payload_t         queue_mem [QUEUE_DEPTH];
  payload_t         rd_data;

  logic             accept;
  logic             emit;
  logic             push;
  logic             pop;
  logic             drop;
  logic             stop;
  logic             go_wait;
  payload_t         pay_sel;
  sum_t             pay_sum;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  always_comb begin
    emit    = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    drop    = 1'b0;
    stop    = 1'b0;
    go_wait = 1'b0;
    pay_sel = msg_reg;
    case (cmd_reg)
      CMD_MSG: begin
        if (!waiting) begin
          emit    = 1'b1;
          go_wait = 1'b1;
          if (queue_count != '0) begin
            pop     = 1'b1;
            push    = 1'b1;
            pay_sel = rd_data;
          end
        end else if (queue_count < CNT_W'(QUEUE_DEPTH)) begin
          push = 1'b1;
        end else begin
          drop = 1'b1;
        end
      end
      CMD_ACK: begin
        stop = (ack_reg == seq_bit);
      end
      CMD_TIMEOUT: begin
        emit    = 1'b1;
        pay_sel = last_payload;
      end
      default: begin
      end
    endcase
  end

  assign head_next = (queue_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : queue_head + 1'b1;
  assign tail_next = (queue_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : queue_tail + 1'b1;

  abs_checksum u_checksum (
    .seq     (seq_bit),
    .payload (pay_sel),
    .sum     (pay_sum)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= queue_mem[queue_head];
    end
    if ((state == ST_EXEC) && push) begin
      queue_mem[queue_tail] <= msg_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg <= command;
      msg_reg <= {msg_word2, msg_word1, msg_word0};
      ack_reg <= ack_bit;
    end
    if ((state == ST_EXEC) && emit) begin
      last_payload <= pay_sel;
    end
    if (state == ST_EXEC) begin
      send_seq   <= emit ? seq_bit : 1'b0;
      send_word0 <= emit ? pay_sel[63:0] : '0;
      send_word1 <= emit ? pay_sel[127:64] : '0;
      send_word2 <= emit ? pay_sel[159:128] : '0;
      send_sum   <= emit ? pay_sum : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      seq_bit     <= 1'b0;
      waiting     <= 1'b0;
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      done        <= 1'b0;
      send_valid  <= 1'b0;
      timer_start <= 1'b0;
      timer_stop  <= 1'b0;
      dropped     <= 1'b0;
    end else begin
      done        <= 1'b0;
      send_valid  <= 1'b0;
      timer_start <= 1'b0;
      timer_stop  <= 1'b0;
      dropped     <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state       <= ST_IDLE;
          done        <= 1'b1;
          send_valid  <= emit;
          timer_start <= emit;
          timer_stop  <= stop;
          dropped     <= drop;
          if (pop) begin
            queue_head <= head_next;
          end
          if (push) begin
            queue_tail <= tail_next;
          end
          if (push && !pop) begin
            queue_count <= queue_count + 1'b1;
          end
          if (go_wait) begin
            waiting <= 1'b1;
          end
          if (stop) begin
            seq_bit <= ~seq_bit;
            waiting <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/tb_alternating_bit_sender_core.sv =====
// Self-checking testbench for the alternating-bit sender core.
`timescale 1ns / 100ps

module tb_alternating_bit_sender_core;
  import abs_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1150;
  localparam int STALL_LIMIT = 500;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic        send_valid;
    logic        send_seq;
    logic [63:0] send_word0;
    logic [63:0] send_word1;
    logic [31:0] send_word2;
    sum_t        send_sum;
    logic        timer_start;
    logic        timer_stop;
    logic        dropped;
  } sender_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [63:0] msg_word0;
  logic [63:0] msg_word1;
  logic [31:0] msg_word2;
  logic        ack_bit;
  logic        done;
  logic        send_valid;
  logic        send_seq;
  logic [63:0] send_word0;
  logic [63:0] send_word1;
  logic [31:0] send_word2;
  sum_t        send_sum;
  logic        timer_start;
  logic        timer_stop;
  logic        dropped;

  alternating_bit_sender_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .msg_word0(msg_word0), .msg_word1(msg_word1), .msg_word2(msg_word2),
    .ack_bit(ack_bit), .done(done), .send_valid(send_valid), .send_seq(send_seq),
    .send_word0(send_word0), .send_word1(send_word1), .send_word2(send_word2),
    .send_sum(send_sum), .timer_start(timer_start), .timer_stop(timer_stop),
    .dropped(dropped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic     seq_bit;
  logic     waiting;
  payload_t last_payload;
  payload_t msg_queue [QUEUE_DEPTH];
  int       queue_head;
  int       queue_tail;
  int       queue_count;

  sender_result_t expected_results [$];
  int error_count = 0;
  int checked_count = 0;
  int packets_sent = 0;
  int acks_taken = 0;
  int drop_count = 0;
  int stall_cycles = 0;
  bit idle_enable = 1'b1;
  bit message_issued = 1'b0;

  function automatic sum_t payload_checksum(input logic seq, input payload_t p);
    int   total;
    byte  b;
    total = int'(seq);
    for (int i = 0; i < NBYTES; i++) begin
      b = p[8*i +: 8];
      total += b;
    end
    return total[SUM_W-1:0];
  endfunction

  function automatic sender_result_t packet_for(input payload_t p);
    sender_result_t r;
    r = '{default: '0};
    r.send_valid = 1'b1;
    r.send_seq = seq_bit;
    r.send_word0 = p[63:0];
    r.send_word1 = p[127:64];
    r.send_word2 = p[159:128];
    r.send_sum = payload_checksum(seq_bit, p);
    r.timer_start = 1'b1;
    last_payload = p;
    packets_sent++;
    return r;
  endfunction

  function automatic void push_message(input payload_t p);
    msg_queue[queue_tail] = p;
    queue_tail = (queue_tail + 1) % QUEUE_DEPTH;
    queue_count++;
  endfunction

  function automatic sender_result_t predict_sender(input logic [1:0] cmd, input payload_t msg,
                                                    input logic ack);
    sender_result_t r;
    payload_t head;
    r = '{default: '0};
    case (cmd)
      CMD_MSG: begin
        if (!waiting) begin
          if (queue_count > 0) begin
            head = msg_queue[queue_head];
            queue_head = (queue_head + 1) % QUEUE_DEPTH;
            queue_count--;
            push_message(msg);
            r = packet_for(head);
          end else begin
            r = packet_for(msg);
          end
          waiting = 1'b1;
        end else if (queue_count < QUEUE_DEPTH) begin
          push_message(msg);
        end else begin
          r.dropped = 1'b1;
          drop_count++;
        end
      end
      CMD_ACK: begin
        if (ack == seq_bit) begin
          seq_bit = ~seq_bit;
          waiting = 1'b0;
          r.timer_stop = 1'b1;
          acks_taken++;
        end
      end
      CMD_TIMEOUT: r = packet_for(last_payload);
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    sender_result_t exp_r;
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, actual send_valid %b",
                   $time, send_valid);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("send_valid", 64'(exp_r.send_valid), 64'(send_valid));
          check_field("send_seq", 64'(exp_r.send_seq), 64'(send_seq));
          check_field("send_word0", exp_r.send_word0, send_word0);
          check_field("send_word1", exp_r.send_word1, send_word1);
          check_field("send_word2", 64'(exp_r.send_word2), 64'(send_word2));
          check_field("send_sum", 64'(exp_r.send_sum), 64'(send_sum));
          check_field("timer_start", 64'(exp_r.timer_start), 64'(timer_start));
          check_field("timer_stop", 64'(exp_r.timer_stop), 64'(timer_stop));
          check_field("dropped", 64'(exp_r.dropped), 64'(dropped));
          checked_count++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_results.push_back(predict_sender(command,
                                                  {msg_word2, msg_word1, msg_word0}, ack_bit));
      end
      if (done === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input payload_t p, input logic ack);
    int gap;
    gap = idle_enable ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    msg_word0 <= p[63:0];
    msg_word1 <= p[127:64];
    msg_word2 <= p[159:128];
    ack_bit <= ack;
    if (cmd == CMD_MSG) message_issued = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  function automatic payload_t random_payload();
    payload_t p;
    case ($urandom_range(0, 9))
      0: p = {NBYTES{8'h80}};
      1: p = {NBYTES{8'h7f}};
      2: p = {NBYTES{8'hff}};
      3: p = '0;
      default: p = {$urandom, $urandom, $urandom, $urandom, $urandom};
    endcase
    return p;
  endfunction

  task automatic test_special_cases();
    send_item(CMD_MSG, {NBYTES{8'h80}}, 1'b0);
    send_item(CMD_TIMEOUT, '0, 1'b0);
    send_item(CMD_ACK, '0, 1'b1);
    send_item(CMD_ACK, '0, 1'b0);
    send_item(CMD_MSG, {NBYTES{8'h7f}}, 1'b1);
    send_item(CMD_UNUSED, {NBYTES{8'hff}}, 1'b1);
    send_item(CMD_ACK, '0, 1'b0);
    send_item(CMD_ACK, '0, 1'b1);
    // A matching acknowledgement while idle still flips the sequence bit.
    send_item(CMD_ACK, '0, 1'b0);
    send_item(CMD_TIMEOUT, '0, 1'b0);
    send_item(CMD_MSG, '0, 1'b0);
  endtask

  task automatic test_queue_overflow();
    for (int i = 0; i <= QUEUE_DEPTH; i++) send_item(CMD_MSG, random_payload(), 1'b0);
    send_item(CMD_ACK, '0, 1'b1);
    send_item(CMD_MSG, random_payload(), 1'b0);
  endtask

  task automatic test_random_traffic();
    int       pick;
    logic [1:0] cmd;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) idle_enable = ~idle_enable;
      pick = $urandom_range(0, 99);
      if (pick < 50) cmd = CMD_MSG;
      else if (pick < 78) cmd = CMD_ACK;
      else if (pick < 95) cmd = CMD_TIMEOUT;
      else cmd = CMD_UNUSED;
      if (cmd == CMD_TIMEOUT && !message_issued) cmd = CMD_MSG;
      send_item(cmd, random_payload(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("[alternating_bit_sender_core] ERROR");
    $finish;
  end

  initial begin
    seq_bit = 1'b0;
    waiting = 1'b0;
    last_payload = '0;
    queue_head = 0;
    queue_tail = 0;
    queue_count = 0;
    rst <= 1'b1;
    start <= 1'b0;
    command <= CMD_MSG;
    msg_word0 <= '0;
    msg_word1 <= '0;
    msg_word2 <= '0;
    ack_bit <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_queue_overflow();
    test_random_traffic();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Checked %0d results: %0d packets sent, %0d acknowledgements taken, %0d drops.",
             checked_count, packets_sent, acks_taken, drop_count);
    $display("Traffic mixed messages, acks, timeouts and unused commands with random gaps.");
    if (error_count == 0) begin
      $display("[alternating_bit_sender_core] OK");
    end else begin
      $display("[alternating_bit_sender_core] ERROR");
    end
    $finish;
  end

endmodule
